### hdl/rgbhsv_pkg.sv
`timescale 1ns / 1ps
package rgbhsv_pkg;

  localparam int QW   = 9;   // quotient bits, enough for 0..511
  localparam int NW   = 29;  // numerator / remainder width
  localparam int DW   = 21;  // denominator width
  localparam int NDIV = QW;  // one restoring step per quotient bit

  localparam logic [8:0]  HUE_FULL  = 9'd360;
  localparam logic [7:0]  CHAN_MAX  = 8'd255;
  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [0:0]  FUNC_TO_HSV = 1'b0;
  localparam logic [0:0]  FUNC_TO_RGB = 1'b1;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          func;
    lane_t [2:0]   lane;
  } divst_t;

  typedef struct packed {
    logic          valid;
    logic          func;
    lane_t [2:0]   lane;
    logic [6:0]    sat;
    logic [6:0]    val;
    logic [2:0]    sector;
    logic [5:0]    k;
  } s1_t;

  typedef struct packed {
    logic          valid;
    logic          func;
    lane_t [2:0]   lane;
    logic [13:0]   vs;
    logic [6:0]    val;
    logic [2:0]    sector;
    logic [5:0]    k;
  } s2_t;

  typedef struct packed {
    logic          valid;
    logic          func;
    lane_t [2:0]   lane;
    logic [19:0]   cc;
    logic [19:0]   xx;
    logic [19:0]   mm;
    logic [2:0]    sector;
  } s3_t;

endpackage

### hdl/rgb_hsv_color_convert_unit.sv
`timescale 1ns / 1ps
// RGB <-> HSV pixel converter.
// Input channel (s_*): s_tuser selects the direction (0: RGB to HSV, 1: HSV to RGB).
// s_tdata carries chan_a, chan_b, chan_c. In RGB mode these are red, green, blue;
// in HSV mode they are hue in degrees, saturation and value in percent.
// Output channel (m_*): m_tdata carries res_a, res_b, res_c, which are hue,
// saturation, value for RGB input, or red, green, blue for HSV input.
// Throughput is one transfer per clock cycle while the receiver does not stall.
// An accepted input transfer reaches m_tvalid through fourteen
// register stages: four arithmetic stages (min/max, hue sector and the value
// reciprocal; the value*saturation product; the chroma products; the color
// channels by reciprocal multiplication), nine restoring divider stages that
// each resolve one quotient bit of hue and saturation, and a rounding/clamp
// output register. Constant-divisor results ride through the divider as is.
// The whole pipeline advances together. When the receiver stalls with a
// result waiting, every stage holds and s_tready drops, so nothing is lost or
// repeated; while the output register is empty or being taken, every stage
// moves one step, empty slots included.
// Synchronous reset clears all valid bits; data registers are not reset.
module rgb_hsv_color_convert_unit
  import rgbhsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // chan_a [8:0], chan_b [16:9], chan_c [24:17], zeros
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // res_a [8:0], res_b [16:9], res_c [24:17], zeros
);

  logic   en;
  s1_t    s1, s1_next;
  s2_t    s2;
  s3_t    s3;
  divst_t dv [0:NDIV];
  logic   out_valid;
  logic   out_func;
  logic [8:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;

  // The whole pipeline moves whenever the output register can take a value.
  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  // Stage 1: clamp inputs; for RGB build the hue and saturation division
  // problems and the value, for HSV find the hue sector and the ramp term.
  always_comb begin
    logic [7:0]  r, g, b, mx, mn, d;
    logic [NW-1:0] nh;
    logic [30:0] vp;
    logic [8:0]  hue;
    logic [7:0]  sb, sc;
    logic [2:0]  sec;
    logic [5:0]  f;
    r  = (s_tdata[8:0] > 9'(CHAN_MAX)) ? CHAN_MAX : s_tdata[7:0];
    g  = s_tdata[16:9];
    b  = s_tdata[24:17];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;

    if (mx == r) begin
      if (g >= b) nh = NW'(60) * NW'(g - b);
      else        nh = NW'(360) * NW'(d) - NW'(60) * NW'(b - g);
    end else if (mx == g) begin
      nh = NW'(120) * NW'(d) + NW'(60) * NW'(b) - NW'(60) * NW'(r);
    end else begin
      nh = NW'(240) * NW'(d) + NW'(60) * NW'(r) - NW'(60) * NW'(g);
    end

    s1_next.valid = s_tvalid;
    s1_next.func  = s_tuser;

    // Each quotient is rounded half up as (2N + D) / (2D).
    if (d == 8'd0) begin
      s1_next.lane[0].rem = '0;
      s1_next.lane[0].den = DW'(1);
    end else begin
      s1_next.lane[0].rem = (nh << 1) + NW'(d);
      s1_next.lane[0].den = DW'({d, 1'b0});
    end
    s1_next.lane[0].quo = '0;

    if (mx == 8'd0) begin
      s1_next.lane[1].rem = '0;
      s1_next.lane[1].den = DW'(1);
    end else begin
      s1_next.lane[1].rem = NW'(200) * NW'(d) + NW'(mx);
      s1_next.lane[1].den = DW'({mx, 1'b0});
    end
    s1_next.lane[1].quo = '0;

    // The value is round(100 * mx / 255) = floor((100 * mx + 127) / 255),
    // taken by a reciprocal multiply that is exact over this range. The lane
    // carries the finished quotient with nothing left for the divider.
    vp = (31'(mx) * 31'd100 + 31'd127) * 31'd32897;
    s1_next.lane[2].rem = '0;
    s1_next.lane[2].den = DW'(1);
    s1_next.lane[2].quo = QW'(vp[30:23]);

    // HSV side: wrap hue once, saturate percentages.
    hue = (s_tdata[8:0] >= HUE_FULL) ? s_tdata[8:0] - HUE_FULL : s_tdata[8:0];
    sb  = s_tdata[16:9];
    sc  = s_tdata[24:17];
    if      (hue >= 9'd300) sec = 3'd5;
    else if (hue >= 9'd240) sec = 3'd4;
    else if (hue >= 9'd180) sec = 3'd3;
    else if (hue >= 9'd120) sec = 3'd2;
    else if (hue >= 9'd60)  sec = 3'd1;
    else                    sec = 3'd0;
    f = 6'(hue - 9'(sec) * 9'd60);
    s1_next.sat    = (sb > 8'(PCT_MAX)) ? PCT_MAX : sb[6:0];
    s1_next.val    = (sc > 8'(PCT_MAX)) ? PCT_MAX : sc[6:0];
    s1_next.sector = sec;
    s1_next.k      = sec[0] ? 6'd60 - f : f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;

      // Stage 2: value times saturation.
      s2.valid  <= s1.valid;
      s2.func   <= s1.func;
      s2.lane   <= s1.lane;
      s2.vs     <= 14'(s1.val) * 14'(s1.sat);
      s2.val    <= s1.val;
      s2.sector <= s1.sector;
      s2.k      <= s1.k;

      // Stage 3: chroma, ramp and offset, all scaled by 600000.
      s3.valid  <= s2.valid;
      s3.func   <= s2.func;
      s3.lane   <= s2.lane;
      s3.cc     <= 20'(s2.vs) * 20'd60;
      s3.xx     <= 20'(s2.vs) * 20'(s2.k);
      s3.mm     <= 20'(s2.val) * 20'd6000 - 20'(s2.vs) * 20'd60;
      s3.sector <= s2.sector;
    end
  end

  // Stage 4: for HSV input, place chroma and ramp into the channels and scale
  // each to a byte. round(255 * n / 600000) equals floor((17n + 20000) / 40000);
  // the divide by 40000 is a shift by six and a reciprocal multiply for 625.
  always_ff @(posedge clk) begin
    logic [19:0] ch [0:2];
    logic [23:0] x;
    logic [35:0] prod;
    case (s3.sector)
      3'd0:    begin ch[0] = s3.cc; ch[1] = s3.xx; ch[2] = '0;    end
      3'd1:    begin ch[0] = s3.xx; ch[1] = s3.cc; ch[2] = '0;    end
      3'd2:    begin ch[0] = '0;    ch[1] = s3.cc; ch[2] = s3.xx; end
      3'd3:    begin ch[0] = '0;    ch[1] = s3.xx; ch[2] = s3.cc; end
      3'd4:    begin ch[0] = s3.xx; ch[1] = '0;    ch[2] = s3.cc; end
      default: begin ch[0] = s3.cc; ch[1] = '0;    ch[2] = s3.xx; end
    endcase
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid <= s3.valid;
      dv[0].func  <= s3.func;
      for (int i = 0; i < 3; i++) begin
        x    = 24'(ch[i] + s3.mm) * 24'd17 + 24'd20000;
        prod = 36'(x[23:6]) * 36'd214749;
        if (s3.func == FUNC_TO_RGB) begin
          dv[0].lane[i].rem <= '0;
          dv[0].lane[i].den <= DW'(1);
          dv[0].lane[i].quo <= prod[35:27];
        end else begin
          dv[0].lane[i] <= s3.lane[i];
        end
      end
    end
  end

  // Restoring divider: stage j resolves quotient bit NDIV-j in each lane.
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int SH = NDIV - j;
    always_ff @(posedge clk) begin
      logic [NW:0] dsh;
      if (rst) begin
        dv[j].valid <= 1'b0;
      end else if (en) begin
        dv[j].valid <= dv[j-1].valid;
        dv[j].func  <= dv[j-1].func;
        for (int i = 0; i < 3; i++) begin
          dsh = (NW+1)'(dv[j-1].lane[i].den) << SH;
          dv[j].lane[i].den <= dv[j-1].lane[i].den;
          if ({1'b0, dv[j-1].lane[i].rem} >= dsh) begin
            dv[j].lane[i].rem <= dv[j-1].lane[i].rem - dsh[NW-1:0];
            dv[j].lane[i].quo <= dv[j-1].lane[i].quo | (QW'(1) << SH);
          end else begin
            dv[j].lane[i].rem <= dv[j-1].lane[i].rem;
            dv[j].lane[i].quo <= dv[j-1].lane[i].quo;
          end
        end
      end
    end
  end

  // Output register: wrap a hue of 360 to 0, clamp color channels to 255.
  always_ff @(posedge clk) begin
    logic [QW-1:0] qa, qb, qc;
    qa = dv[NDIV].lane[0].quo;
    qb = dv[NDIV].lane[1].quo;
    qc = dv[NDIV].lane[2].quo;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[NDIV].valid;
      out_func  <= dv[NDIV].func;
      if (dv[NDIV].func == FUNC_TO_HSV)
        out_a <= (qa >= HUE_FULL) ? qa - HUE_FULL : qa;
      else
        out_a <= (qa > 9'(CHAN_MAX)) ? 9'(CHAN_MAX) : qa;
      out_b <= (qb > 9'(CHAN_MAX)) ? CHAN_MAX : qb[7:0];
      out_c <= (qc > 9'(CHAN_MAX)) ? CHAN_MAX : qc[7:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_c, out_b, out_a};

  // The last divider step must leave every remainder below its divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv[NDIV].valid |-> (dv[NDIV].lane[0].rem < NW'(dv[NDIV].lane[0].den)) &&
                       (dv[NDIV].lane[1].rem < NW'(dv[NDIV].lane[1].den)) &&
                       (dv[NDIV].lane[2].rem < NW'(dv[NDIV].lane[2].den)))
    else $error("divider remainder not reduced");

  // HSV results stay in range.
  a_hsv_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_func == FUNC_TO_HSV) |->
      (out_a < HUE_FULL) && (out_b <= 8'(PCT_MAX)) && (out_c <= 8'(PCT_MAX)))
    else $error("HSV result out of range");

  // A stalled result keeps the pipeline frozen.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> $stable(dv[NDIV].valid) && $stable(s1.valid))
    else $error("pipeline moved during stall");

endmodule
